/* hdl/ptb_pkg.sv */
// Shared types and constants for the periodic timer bank.
// Holds the request, result and slot record structs, the command and result
// codes and the sequencer state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  // Default sizing of the bank.
  localparam int unsigned NumSlotsDefault = 8;
  localparam int unsigned TickBitsDefault = 32;

  // Field widths fixed by the interface.
  localparam int unsigned TickW   = 32;
  localparam int unsigned DivdW   = TickW + 1;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned TotalW  = 36;

  // Command codes of a request.
  localparam logic [1:0] CMD_SUB   = 2'd0;
  localparam logic [1:0] CMD_UNSUB = 2'd1;
  localparam logic [1:0] CMD_ADV   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SUB   = 2'd0;
  localparam logic [1:0] KIND_UNSUB = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // One request transaction.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [TickW-1:0] period;
    logic [TickW-1:0] target_id;
    logic [TickW-1:0] delta;
  } ptb_in_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]        kind;
    logic              ok;
    logic [TickW-1:0]  slot_ident;
    logic [TickW-1:0]  slot_period;
    logic [DivdW-1:0]  fires;
    logic [TickW-1:0]  fire_count;
    logic [TimeW-1:0]  time_now;
    logic [TotalW-1:0] fire_total;
    logic              last;
  } ptb_out_t;

  // One slot as kept in the slot memory, with the firings of the last advance.
  typedef struct packed {
    logic [TickW-1:0] id;
    logic [TickW-1:0] interval;
    logic [TickW-1:0] accum;
    logic [TickW-1:0] fired;
    logic [DivdW-1:0] nf;
  } ptb_rec_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_UNS_RD,
    ST_UNS_CHK,
    ST_ADV_START,
    ST_ADV_RD,
    ST_ADV_LOAD,
    ST_ADV_DIV,
    ST_REP_INIT,
    ST_REP_RD,
    ST_REP_CHK,
    ST_REP_EMIT
  } ptb_state_e;

endpackage

`default_nettype wire

/* hdl/ptb_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// Used for the slot records. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ptb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/ptb_divider.sv */
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 32-bit divisor.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptb_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ptb_pkg::DivdW-1:0]  dividend_i,
  input  wire logic [ptb_pkg::TickW-1:0]  divisor_i,
  output logic                            done_o,
  output logic      [ptb_pkg::DivdW-1:0]  quot_o,
  output logic      [ptb_pkg::TickW-1:0]  rem_o
);

  import ptb_pkg::*;

  localparam int unsigned CntW = $clog2(DivdW);
  localparam logic [CntW-1:0] LastStep = CntW'(DivdW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivdW-1:0] quo_q, quo_d;
  logic [TickW-1:0] rem_q, rem_d;
  logic [TickW-1:0] div_q, div_d;
  logic [DivdW-1:0] trial;
  logic             take;

  // One step: shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, quo_q[DivdW-1]};
  assign take  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivdW-2:0], take};
      rem_d = take ? TickW'(trial - {1'b0, div_q}) : TickW'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  // The remainder is always below a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (div_q != '0) && (rem_o < div_q))
    else $error("divider remainder not below divisor");

  // Done is a single-cycle pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done held longer than one cycle");

  // A new division is never started while one is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider started while busy");

endmodule

`default_nettype wire

/* hdl/periodic_timer_bank.sv */
// Periodic timer bank top level: sequencer, slot memory and shared 33-step divider.
// Depends on ptb_pkg, ptb_ram and ptb_divider. Reset empties every slot, id counter 1.
// Advance runs one division per live slot, then one report pass per fired slot and a
// last one for the total; every result leaves through the output register. One
// transaction at a time: busy drops in the cycle of the last result, when the next
// one can be accepted.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank #(
  parameter int unsigned NUM_SLOTS = ptb_pkg::NumSlotsDefault,
  parameter int unsigned TICK_BITS = ptb_pkg::TickBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ptb_pkg::ptb_in_t  req_i,
  output logic                   out_valid_o,
  output ptb_pkg::ptb_out_t      res_o
);

  import ptb_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);
  localparam int unsigned TW = (TICK_BITS > TickW) ? TickW : TICK_BITS;
  localparam logic [TickW-1:0] TickMask = {TickW{1'b1}} >> (TickW - TW);
  localparam int unsigned RecW = $bits(ptb_rec_t);

  ptb_state_e         state_q, state_d;
  ptb_in_t            req_q, req_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic               found_q, found_d;
  ptb_rec_t           best_q, best_d;
  ptb_rec_t           rec_q, rec_d;
  logic [TickW-1:0]   id_ctr_q, id_ctr_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [TotalW-1:0]  total_q, total_d;
  ptb_out_t           res_q, res_d;
  logic               valid_q, valid_d;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  ptb_rec_t           ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [RecW-1:0]    ram_rdata;
  ptb_rec_t           rd_rec;

  logic               div_start;
  logic [DivdW-1:0]   div_dividend;
  logic               div_done;
  logic [DivdW-1:0]   div_quot;
  logic [TickW-1:0]   div_rem;

  logic [TickW-1:0]   per_m;
  logic [TickW-1:0]   dt_m;
  logic [IW-1:0]      free_idx;
  logic               free_ok;

  assign per_m  = req_q.period & TickMask;
  assign dt_m   = req_q.delta & TickMask;
  assign rd_rec = ptb_rec_t'(ram_rdata);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  // Slot record memory.
  ptb_ram #(
    .WIDTH (RecW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared divider for the per-slot firing count.
  assign div_dividend = {1'b0, rd_rec.accum} + {1'b0, dt_m};

  ptb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rd_rec.interval),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Sequencer: next state, memory access and result forming.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    used_d     = used_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    best_d     = best_q;
    rec_d      = rec_q;
    id_ctr_d   = id_ctr_q;
    time_d     = time_q;
    total_d    = total_q;
    res_d      = '0;
    valid_d    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = rec_q;
    ram_raddr  = idx_q;
    div_start  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          idx_d = '0;
          unique case (req_i.cmd)
            CMD_SUB:   state_d = ST_SUB;
            CMD_UNSUB: state_d = ST_UNS_RD;
            CMD_ADV:   state_d = ST_ADV_START;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      // Take the lowest free slot, or reject.
      ST_SUB: begin
        valid_d     = 1'b1;
        res_d.kind  = KIND_SUB;
        res_d.last  = 1'b1;
        if (per_m != '0 && free_ok) begin
          ram_we             = 1'b1;
          ram_waddr          = free_idx;
          ram_wdata          = '0;
          ram_wdata.id       = id_ctr_q;
          ram_wdata.interval = per_m;
          used_d[free_idx]   = 1'b1;
          res_d.ok           = 1'b1;
          res_d.slot_ident   = id_ctr_q;
          id_ctr_d           = id_ctr_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      // Unsubscribe walks the live slots for the first matching id.
      ST_UNS_RD: begin
        if (used_q[idx_q]) begin
          state_d = ST_UNS_CHK;
        end else if (idx_q == LastIdx) begin
          valid_d    = 1'b1;
          res_d.kind = KIND_UNSUB;
          res_d.last = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_UNS_CHK: begin
        if (rd_rec.id == req_q.target_id) begin
          used_d[idx_q] = 1'b0;
          valid_d       = 1'b1;
          res_d.kind    = KIND_UNSUB;
          res_d.ok      = 1'b1;
          res_d.last    = 1'b1;
          state_d       = ST_IDLE;
        end else if (idx_q == LastIdx) begin
          valid_d    = 1'b1;
          res_d.kind = KIND_UNSUB;
          res_d.last = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_UNS_RD;
        end
      end

      // Advance: a zero step only reports the total.
      ST_ADV_START: begin
        total_d = '0;
        pend_d  = '0;
        idx_d   = '0;
        if (dt_m == '0) begin
          valid_d        = 1'b1;
          res_d.kind     = KIND_DONE;
          res_d.time_now = time_q;
          res_d.last     = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          time_d  = time_q + TimeW'(dt_m);
          state_d = ST_ADV_RD;
        end
      end

      ST_ADV_RD: begin
        if (used_q[idx_q]) begin
          state_d = ST_ADV_LOAD;
        end else if (idx_q == LastIdx) begin
          state_d = ST_REP_INIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // The record is on the read port: start the division.
      ST_ADV_LOAD: begin
        rec_d     = rd_rec;
        div_start = 1'b1;
        state_d   = ST_ADV_DIV;
      end

      // Write back remainder, count and firings of this slot.
      ST_ADV_DIV: begin
        if (div_done) begin
          ram_we          = 1'b1;
          ram_wdata       = rec_q;
          ram_wdata.accum = div_rem;
          ram_wdata.fired = rec_q.fired + div_quot[TickW-1:0];
          ram_wdata.nf    = div_quot;
          pend_d[idx_q]   = (div_quot != '0);
          total_d         = total_q + TotalW'(div_quot);
          if (idx_q == LastIdx) begin
            state_d = ST_REP_INIT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_ADV_RD;
          end
        end
      end

      // Report: each pass picks the pending slot with the lowest id.
      ST_REP_INIT: begin
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ST_REP_RD;
      end

      ST_REP_RD: begin
        if (pend_q[idx_q]) begin
          state_d = ST_REP_CHK;
        end else if (idx_q == LastIdx) begin
          state_d = ST_REP_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_REP_CHK: begin
        if (!found_q || rd_rec.id < best_q.id) begin
          found_d    = 1'b1;
          best_d     = rd_rec;
          best_idx_d = idx_q;
        end
        if (idx_q == LastIdx) begin
          state_d = ST_REP_EMIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_REP_RD;
        end
      end

      ST_REP_EMIT: begin
        valid_d        = 1'b1;
        res_d.time_now = time_q;
        if (found_q) begin
          res_d.kind           = KIND_FIRED;
          res_d.slot_ident     = best_q.id;
          res_d.slot_period    = best_q.interval;
          res_d.fires          = best_q.nf;
          res_d.fire_count     = best_q.fired;
          pend_d[best_idx_q]   = 1'b0;
          state_d              = ST_REP_INIT;
        end else begin
          res_d.kind       = KIND_DONE;
          res_d.fire_total = total_q;
          res_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      pend_q   <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      id_ctr_q <= TickW'(1);
      time_q   <= '0;
      total_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      id_ctr_q <= id_ctr_d;
      time_q   <= time_d;
      total_q  <= total_d;
      valid_q  <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rec_q      <= rec_d;
    res_q      <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // No slot is left pending once the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pend_q == '0))
    else $error("pending report left after advance");

  // A successful subscribe reply hands out the id just before the counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.kind == KIND_SUB && res_o.ok) |->
      (id_ctr_q == res_o.slot_ident + 1'b1))
    else $error("id counter out of step with subscribe reply");

  // Fired reports are never the last transaction of an advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.kind == KIND_FIRED) |-> !res_o.last)
    else $error("fired report marked last");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_ADV_DIV))
    else $error("divider result outside the division state");

endmodule

`default_nettype wire

/* bench/timer_bank_checker.sv */
// Checker for the periodic timer bank: watches the request and result channels.
// Predicts every result transaction from its own copy of the slot table and
// compares it field by field. Depends on ptb_pkg.
`timescale 1ns / 1ps

module timer_bank_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  ptb_pkg::ptb_in_t  req_i,
  input  logic              out_valid_o,
  input  ptb_pkg::ptb_out_t res_o,
  output int unsigned       errors_o,
  output int unsigned       due_count_o
);
  import ptb_pkg::*;

  localparam int unsigned NSlots = NumSlotsDefault;

  // Shadow of the slot table and the global counters.
  logic        slot_live  [NSlots];
  logic [31:0] slot_tag   [NSlots];
  logic [31:0] slot_step  [NSlots];
  logic [31:0] slot_phase [NSlots];
  logic [31:0] slot_hits  [NSlots];
  logic [31:0] next_id;
  logic [63:0] now_ticks;

  ptb_out_t    due_results[$];
  int unsigned errors;

  // Appends one predicted result transaction to the due queue.
  task automatic queue_result(input ptb_out_t r);
    due_results = {due_results, r};
  endtask

  // Applies one accepted request to the shadow table and queues its results.
  task automatic predict_command(input ptb_in_t req);
    ptb_out_t    r;
    int          free_slot;
    int          best;
    logic        found;
    logic [32:0] sum;
    logic [32:0] rem;
    logic [32:0] nf [NSlots];
    logic        to_report [NSlots];
    logic [35:0] total;
    free_slot = -1;
    found     = 1'b0;
    total     = '0;
    r         = '0;
    case (req.cmd)
      CMD_SUB: begin
        for (int i = 0; i < NSlots; i++) begin
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        end
        r.kind = KIND_SUB;
        r.last = 1'b1;
        if (req.period != '0 && free_slot >= 0) begin
          slot_live[free_slot]  = 1'b1;
          slot_tag[free_slot]   = next_id;
          slot_step[free_slot]  = req.period;
          slot_phase[free_slot] = '0;
          slot_hits[free_slot]  = '0;
          r.ok         = 1'b1;
          r.slot_ident = next_id;
          next_id      = next_id + 32'd1;
        end
        queue_result(r);
      end
      CMD_UNSUB: begin
        // The lowest-index slot holding the id is freed.
        for (int i = 0; i < NSlots; i++) begin
          if (!found && slot_live[i] && slot_tag[i] == req.target_id) begin
            slot_live[i] = 1'b0;
            found        = 1'b1;
          end
        end
        r.kind = KIND_UNSUB;
        r.ok   = found;
        r.last = 1'b1;
        queue_result(r);
      end
      CMD_ADV: begin
        for (int i = 0; i < NSlots; i++) begin
          nf[i]        = '0;
          to_report[i] = 1'b0;
        end
        // A zero delta leaves time alone and fires nothing.
        if (req.delta != '0) begin
          now_ticks = now_ticks + {32'd0, req.delta};
          for (int i = 0; i < NSlots; i++) begin
            if (slot_live[i] && slot_step[i] != '0) begin
              sum           = {1'b0, slot_phase[i]} + {1'b0, req.delta};
              nf[i]         = sum / {1'b0, slot_step[i]};
              rem           = sum % {1'b0, slot_step[i]};
              slot_phase[i] = rem[31:0];
              slot_hits[i]  = slot_hits[i] + nf[i][31:0];
              total         = total + {3'd0, nf[i]};
              to_report[i]  = (nf[i] != '0);
            end
          end
          // Fired slots go out in ascending id order, ties by slot index.
          for (int k = 0; k < NSlots; k++) begin
            best = -1;
            for (int j = 0; j < NSlots; j++) begin
              if (to_report[j] && (best < 0 || slot_tag[j] < slot_tag[best])) best = j;
            end
            if (best >= 0) begin
              to_report[best] = 1'b0;
              r             = '0;
              r.kind        = KIND_FIRED;
              r.slot_ident  = slot_tag[best];
              r.slot_period = slot_step[best];
              r.fires       = nf[best];
              r.fire_count  = slot_hits[best];
              r.time_now    = now_ticks;
              queue_result(r);
            end
          end
        end
        r            = '0;
        r.kind       = KIND_DONE;
        r.time_now   = now_ticks;
        r.fire_total = total;
        r.last       = 1'b1;
        queue_result(r);
      end
      default: begin
        // The unused command code is dropped without a result.
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Prediction on every accepted request, comparison on every result strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    ptb_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NSlots; i++) begin
        slot_live[i]  = 1'b0;
        slot_tag[i]   = '0;
        slot_step[i]  = '0;
        slot_phase[i] = '0;
        slot_hits[i]  = '0;
      end
      next_id   = 32'd1;
      now_ticks = '0;
      due_results.delete();
      errors      = 0;
      errors_o    <= 0;
      due_count_o <= 0;
    end else begin
      if (start === 1'b1 && busy === 1'b0) predict_command(req_i);
      if (out_valid_o === 1'b1) begin
        if (due_results.size() == 0) begin
          $error("result transaction with none due: kind %0d", res_o.kind);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("kind",        64'(want.kind),        64'(res_o.kind));
          check_field("ok",          64'(want.ok),          64'(res_o.ok));
          check_field("slot_ident",  64'(want.slot_ident),  64'(res_o.slot_ident));
          check_field("slot_period", 64'(want.slot_period), 64'(res_o.slot_period));
          check_field("fires",       64'(want.fires),       64'(res_o.fires));
          check_field("fire_count",  64'(want.fire_count),  64'(res_o.fire_count));
          check_field("time_now",    want.time_now,         res_o.time_now);
          check_field("fire_total",  64'(want.fire_total),  64'(res_o.fire_total));
          check_field("last",        64'(want.last),        64'(res_o.last));
        end
      end
      errors_o    <= errors;
      due_count_o <= due_results.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the periodic timer bank testbench: clock, reset, request stimulus, verdict.
// Depends on ptb_pkg, periodic_timer_bank and timer_bank_checker.
`timescale 1ns / 1ps

module tb_top;
  import ptb_pkg::*;

  // Code that the block ignores.
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int unsigned RandItems   = 246;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned SettleTicks = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  ptb_in_t     req_i       = '0;
  logic        busy;
  logic        out_valid_o;
  ptb_out_t    res_o;
  int unsigned errors;
  int unsigned due_count;
  int unsigned idle_cycles = 0;
  logic        no_gaps     = 1'b0;
  int unsigned subs_sent   = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  periodic_timer_bank DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_o)
  );

  timer_bank_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_o),
    .errors_o    (errors),
    .due_count_o (due_count)
  );

  // Builds a request; the fields the command does not use carry random bits.
  function automatic ptb_in_t make_req(input logic [1:0] cmd, input logic [31:0] value);
    ptb_in_t r;
    r.cmd       = cmd;
    r.period    = $urandom;
    r.target_id = $urandom;
    r.delta     = $urandom;
    case (cmd)
      CMD_SUB:   r.period    = value;
      CMD_UNSUB: r.target_id = value;
      CMD_ADV:   r.delta     = value;
      default:   r.period    = value;
    endcase
    return r;
  endfunction

  // Issues one request transaction after a random gap and waits for its acceptance.
  task automatic send_req(input ptb_in_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (r.cmd == CMD_SUB) subs_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Random request with the field value drawn per command.
  task automatic send_random_req();
    int unsigned roll;
    int unsigned pick;
    int unsigned lo;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    if (roll < 30) begin
      if (pick < 2) value = '0;
      else if (pick < 14) value = $urandom_range(1, 40);
      else if (pick < 18) value = $urandom_range(41, 5000);
      else value = $urandom;
      send_req(make_req(CMD_SUB, value));
    end else if (roll < 55) begin
      // Mostly ids handed out recently, so that removals often hit.
      lo = (subs_sent > 12) ? subs_sent - 12 : 0;
      value = (pick < 2) ? $urandom : $urandom_range(lo, subs_sent + 1);
      send_req(make_req(CMD_UNSUB, value));
    end else if (roll < 95) begin
      if (pick < 1) value = '0;
      else if (pick < 13) value = $urandom_range(1, 60);
      else if (pick < 18) value = $urandom_range(61, 20000);
      else value = $urandom;
      send_req(make_req(CMD_ADV, value));
    end else begin
      send_req(make_req(CMD_NONE, $urandom));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, rejects, a full table and the field extremes.
    send_req(make_req(CMD_ADV, 32'd0));
    send_req(make_req(CMD_ADV, 32'd5));
    send_req(make_req(CMD_SUB, 32'd0));
    send_req(make_req(CMD_UNSUB, 32'd77));
    send_req(make_req(CMD_SUB, 32'd1));
    send_req(make_req(CMD_SUB, 32'hFFFF_FFFF));
    send_req(make_req(CMD_SUB, 32'd3));
    send_req(make_req(CMD_SUB, 32'd7));
    send_req(make_req(CMD_SUB, 32'd100));
    send_req(make_req(CMD_SUB, 32'd1000));
    send_req(make_req(CMD_SUB, 32'd2));
    send_req(make_req(CMD_SUB, 32'd5));
    send_req(make_req(CMD_SUB, 32'd9));
    send_req(make_req(CMD_ADV, 32'hFFFF_FFFF));
    send_req(make_req(CMD_ADV, 32'd0));
    send_req(make_req(CMD_ADV, 32'd1));
    send_req(make_req(CMD_UNSUB, 32'd1));
    send_req(make_req(CMD_UNSUB, 32'd1));
    send_req(make_req(CMD_UNSUB, 32'd8));
    send_req(make_req(CMD_SUB, 32'h8000_0000));
    send_req(make_req(CMD_NONE, 32'hFFFF_FFFF));
    send_req(make_req(CMD_ADV, 32'h7FFF_FFFF));
    send_req(make_req(CMD_UNSUB, 32'd0));
    send_req(make_req(CMD_UNSUB, 32'hFFFF_FFFF));

    // Random part in phases, some of them without gaps.
    for (int n = 0; n < RandItems; n++) begin
      if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_random_req();
    end
    start <= 1'b0;

    // Let busy and the due count reflect the last acceptance before waiting.
    @(posedge clk_i);
    while (due_count != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog on cycles that see neither a request nor a result transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || out_valid_o === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
